// ----- rtl/framed_command_receiver_assert.svh -----
// Assertion macros shared by the framed command receiver RTL.
// No dependencies; included by the modules that carry concurrent assertions.
`ifndef FRAMED_COMMAND_RECEIVER_ASSERT_SVH
`define FRAMED_COMMAND_RECEIVER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define FCR_ASSERT_NOW(lbl, clk_i, rst_i, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (rst_i) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define FCR_ASSERT_NEXT(lbl, clk_i, rst_i, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (rst_i) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ----- rtl/fcr_pkg.sv -----
// Shared types, constants and decode functions for the framed command receiver.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package fcr_pkg;

  // Framing constants.
  localparam logic [7:0] START_BYTE    = 8'h50;
  localparam logic [4:0] LONG_BODY     = 5'd19;
  localparam logic [4:0] SHORT_BODY    = 5'd10;
  localparam logic [4:0] ID_BYTES      = 5'd8;
  localparam int         PAYLOAD_BYTES = 9;
  localparam int         PAY_IDX_W     = $clog2(PAYLOAD_BYTES);

  // Frame type codes as they appear on the wire.
  localparam logic [7:0] TYPE_STORE      = 8'h10;
  localparam logic [7:0] TYPE_FETCH      = 8'h11;
  localparam logic [7:0] TYPE_DEPORT_XFR = 8'h12;
  localparam logic [7:0] TYPE_STATION_XFR = 8'h13;
  localparam logic [7:0] TYPE_INQUIRY    = 8'h14;
  localparam logic [7:0] TYPE_DELETE     = 8'h15;
  localparam logic [7:0] TYPE_ERROR_ACK  = 8'h20;
  localparam logic [7:0] TYPE_STATE_ACK  = 8'h21;

  // Receiver phase.
  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_TYPE = 2'd1,
    PH_BODY = 2'd2
  } phase_t;

  // Frame kind as reported on the result channel.
  typedef enum logic [2:0] {
    KIND_STORE       = 3'd0,
    KIND_FETCH       = 3'd1,
    KIND_DEPORT_XFR  = 3'd2,
    KIND_STATION_XFR = 3'd3,
    KIND_INQUIRY     = 3'd4,
    KIND_DELETE      = 3'd5,
    KIND_ERROR_ACK   = 3'd6,
    KIND_STATE_ACK   = 3'd7
  } frame_kind_t;

  // Result of decoding a type byte.
  typedef struct packed {
    logic        known;
    frame_kind_t kind;
  } type_dec_t;

  // One decoded frame.
  typedef struct packed {
    frame_kind_t                          kind;
    logic [63:0]                          mission_id;
    logic [PAYLOAD_BYTES-1:0][7:0]        payload;
  } frame_res_t;

  // Map a type byte to its kind; unknown types are flagged.
  function automatic type_dec_t decode_type(input logic [7:0] t);
    type_dec_t d;
    d.known = 1'b1;
    d.kind  = KIND_STORE;
    unique case (t)
      TYPE_STORE:       d.kind = KIND_STORE;
      TYPE_FETCH:       d.kind = KIND_FETCH;
      TYPE_DEPORT_XFR:  d.kind = KIND_DEPORT_XFR;
      TYPE_STATION_XFR: d.kind = KIND_STATION_XFR;
      TYPE_INQUIRY:     d.kind = KIND_INQUIRY;
      TYPE_DELETE:      d.kind = KIND_DELETE;
      TYPE_ERROR_ACK:   d.kind = KIND_ERROR_ACK;
      TYPE_STATE_ACK:   d.kind = KIND_STATE_ACK;
      default:          d.known = 1'b0;
    endcase
    return d;
  endfunction

  // Body length in bytes: the four transfer kinds carry a payload.
  function automatic logic [4:0] body_len(input frame_kind_t k);
    return k[2] ? SHORT_BODY : LONG_BODY;
  endfunction

endpackage

// ----- rtl/fcr_in_reg.sv -----
// Input register for received bytes, with valid/ready handshake.
// Depends on fcr_pkg.
`timescale 1ns / 1ps

module fcr_in_reg (
  input  logic       clk,
  input  logic       rst,
  input  logic       rx_valid,
  output logic       rx_ready,
  input  logic [7:0] rx_byte,
  output logic       byte_valid,
  output logic [7:0] byte_data,
  input  logic       byte_taken
);
  import fcr_pkg::*;

  logic       full;
  logic [7:0] data;

  // A new beat may enter when the register is empty or is being drained.
  assign rx_ready   = !full || byte_taken;
  assign byte_valid = full;
  assign byte_data  = data;

  // Occupancy flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (rx_valid && rx_ready) begin
      full <= 1'b1;
    end else if (byte_taken) begin
      full <= 1'b0;
    end
  end

  // Byte capture.
  always_ff @(posedge clk) begin
    if (rx_valid && rx_ready) begin
      data <= rx_byte;
    end
  end

endmodule

// ----- rtl/fcr_parser.sv -----
// Frame parser: start-byte hunt, type decode, id and payload capture, checksum.
// Depends on fcr_pkg and framed_command_receiver_assert.svh.
`timescale 1ns / 1ps
`include "framed_command_receiver_assert.svh"

module fcr_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               byte_valid,
  input  logic [7:0]         byte_data,
  output logic               byte_taken,
  input  logic               res_space,
  output logic               res_valid,
  output fcr_pkg::frame_res_t res
);
  import fcr_pkg::*;

  phase_t                        phase, phase_next;
  frame_kind_t                   kind_reg, kind_next;
  logic [4:0]                    bytes_left, left_next;
  logic [7:0]                    running_sum, sum_next;
  logic [63:0]                   id_shift, id_next;
  logic [PAYLOAD_BYTES-1:0][7:0] payload, pay_next;

  logic       step;
  logic [4:0] len;
  logic [4:0] pos;
  logic [4:0] pay_idx;
  logic       body_bad;
  logic       is_tail;
  logic       is_csum;
  type_dec_t  dec;

  // A byte is consumed only when the result register can take a result.
  assign step       = byte_valid && res_space;
  assign byte_taken = step;

  // Position decode within the body.
  assign dec      = decode_type(byte_data);
  assign len      = body_len(kind_reg);
  assign pos      = 5'(len - bytes_left);
  assign pay_idx  = 5'(pos - ID_BYTES);
  assign body_bad = (bytes_left == 5'd0) || (bytes_left > len);
  assign is_tail  = (bytes_left == 5'd1);
  assign is_csum  = (bytes_left == 5'd2);

  // Next-state logic.
  always_comb begin
    phase_next = phase;
    kind_next  = kind_reg;
    left_next  = bytes_left;
    sum_next   = running_sum;
    id_next    = id_shift;
    pay_next   = payload;
    if (step) begin
      unique case (phase)
        PH_TYPE: begin
          if (dec.known) begin
            kind_next  = dec.kind;
            left_next  = body_len(dec.kind);
            sum_next   = byte_data;
            phase_next = PH_BODY;
          end else begin
            phase_next = PH_HUNT;
          end
        end
        PH_BODY: begin
          if (body_bad) begin
            phase_next = PH_HUNT;
          end else begin
            left_next = 5'(bytes_left - 5'd1);
            if (is_tail) begin
              phase_next = PH_HUNT;
            end else if (is_csum) begin
              sum_next = 8'(running_sum - byte_data);
            end else begin
              sum_next = 8'(running_sum + byte_data);
              if (pos < ID_BYTES) begin
                id_next = {id_shift[55:0], byte_data};
              end else if (pay_idx < 5'(PAYLOAD_BYTES)) begin
                pay_next[pay_idx[PAY_IDX_W-1:0]] = byte_data;
              end
            end
          end
        end
        default: begin
          // Hunting; the unused phase code behaves the same way.
          if (byte_data == START_BYTE) begin
            phase_next = PH_TYPE;
            left_next  = 5'd0;
            sum_next   = 8'd0;
            id_next    = 64'd0;
            pay_next   = '0;
          end else begin
            phase_next = PH_HUNT;
          end
        end
      endcase
    end
  end

  // Result outputs: a good frame is reported on its tail byte.
  always_comb begin
    res_valid      = step && (phase == PH_BODY) && !body_bad && is_tail &&
                     (running_sum == 8'd0);
    res.kind       = kind_reg;
    res.mission_id = id_shift;
    res.payload    = payload;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HUNT;
      bytes_left <= 5'd0;
    end else begin
      phase      <= phase_next;
      bytes_left <= left_next;
    end
  end

  // Frame data, set at each start and type byte, so no reset is needed.
  always_ff @(posedge clk) begin
    kind_reg    <= kind_next;
    running_sum <= sum_next;
    id_shift    <= id_next;
    payload     <= pay_next;
  end

  // The body counter stays within the length of the current frame.
  `FCR_ASSERT_NOW(a_left_in_range, clk, rst, phase == PH_BODY,
                  bytes_left != 5'd0 && bytes_left <= body_len(kind_reg))
  // A start byte while hunting opens a fresh frame with cleared accumulators.
  `FCR_ASSERT_NEXT(a_start_clears, clk, rst,
                   step && phase != PH_TYPE && phase != PH_BODY &&
                   byte_data == START_BYTE,
                   phase == PH_TYPE && running_sum == 8'd0 && id_shift == 64'd0)
  // Short frames never carry payload bytes into the result.
  `FCR_ASSERT_NOW(a_short_no_payload, clk, rst, res_valid && res.kind[2],
                  res.payload == '0)

endmodule

// ----- rtl/fcr_out_reg.sv -----
// Result register holding one decoded frame for the downstream handshake.
// Depends on fcr_pkg.
`timescale 1ns / 1ps

module fcr_out_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                res_valid,
  input  fcr_pkg::frame_res_t res,
  output logic                res_space,
  output logic                frame_valid,
  input  logic                frame_ready,
  output fcr_pkg::frame_res_t frame
);
  import fcr_pkg::*;

  logic       valid;
  frame_res_t data;

  // The register can load whenever it is empty or its beat leaves this cycle.
  assign res_space   = !valid || frame_ready;
  assign frame_valid = valid;
  assign frame       = data;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (res_space) begin
      valid <= res_valid;
    end
  end

  // Result capture.
  always_ff @(posedge clk) begin
    if (res_space && res_valid) begin
      data <= res;
    end
  end

endmodule

// ----- rtl/framed_command_receiver.sv -----
// Framed command receiver: byte stream in, one beat per good frame out.
// Input channel rx_valid/rx_ready/rx_byte carries one received byte per beat.
// The block hunts for the start byte, decodes the type byte, collects the
// eight big-endian id bytes and, for the four transfer kinds, nine payload
// bytes, and checks the modulo-256 sum against the checksum byte.
// Output channel frame_valid/frame_ready carries the kind, mission id and
// payload fields of a good frame; short frames report zero payload fields.
// Frames with a bad checksum or an unknown type produce no beat.
// Throughput: one byte per cycle while the result register has space, set
// by the combinational parse step between the input and result registers.
// Output timing: the tail byte's beat is loaded into the input register,
// and frame_valid rises when the result register then loads the result,
// which waits while the result register has no space.
// Reset: synchronous, active high; the block returns to hunting and both
// registers empty.
// Stalls: while a result waits with frame_ready low, the parser holds and
// rx_ready falls as soon as the input register is full.
`timescale 1ns / 1ps

module framed_command_receiver (
  input  logic        clk,
  input  logic        rst,
  input  logic        rx_valid,
  output logic        rx_ready,
  input  logic [7:0]  rx_byte,
  output logic        frame_valid,
  input  logic        frame_ready,
  output logic [2:0]  frame_kind,
  output logic [63:0] mission_id,
  output logic [7:0]  station_a,
  output logic [7:0]  station_b,
  output logic [7:0]  src_col,
  output logic [7:0]  src_row,
  output logic [7:0]  src_layer,
  output logic [7:0]  dst_col,
  output logic [7:0]  dst_row,
  output logic [7:0]  dst_layer,
  output logic [7:0]  priority_res
);
  import fcr_pkg::*;

  logic       byte_valid;
  logic [7:0] byte_data;
  logic       byte_taken;
  logic       res_space;
  logic       res_valid;
  frame_res_t res;
  frame_res_t frame;

  // Input register.
  fcr_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .rx_valid   (rx_valid),
    .rx_ready   (rx_ready),
    .rx_byte    (rx_byte),
    .byte_valid (byte_valid),
    .byte_data  (byte_data),
    .byte_taken (byte_taken)
  );

  // Frame parser.
  fcr_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_data  (byte_data),
    .byte_taken (byte_taken),
    .res_space  (res_space),
    .res_valid  (res_valid),
    .res        (res)
  );

  // Result register.
  fcr_out_reg u_out_reg (
    .clk         (clk),
    .rst         (rst),
    .res_valid   (res_valid),
    .res         (res),
    .res_space   (res_space),
    .frame_valid (frame_valid),
    .frame_ready (frame_ready),
    .frame       (frame)
  );

  // Field breakout of the result beat.
  assign frame_kind   = frame.kind;
  assign mission_id   = frame.mission_id;
  assign station_a    = frame.payload[0];
  assign station_b    = frame.payload[1];
  assign src_col      = frame.payload[2];
  assign src_row      = frame.payload[3];
  assign src_layer    = frame.payload[4];
  assign dst_col      = frame.payload[5];
  assign dst_row      = frame.payload[6];
  assign dst_layer    = frame.payload[7];
  assign priority_res = frame.payload[8];

endmodule
